// ===== rtl/vaos_pkg.sv =====
// ----------------------------------------------------------------------------
// vaos_pkg
// Shared types and constants for the oldest-steal voice allocator.
// ----------------------------------------------------------------------------
package vaos_pkg;

    // default number of voice slots
    localparam int VOICES_DEF = 32;

    // command codes
    localparam logic [1:0] CMD_LEASE  = 2'd0;
    localparam logic [1:0] CMD_RETURN = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;
    localparam logic [1:0] CMD_LOAD   = 2'd3;

    // slot state codes
    localparam logic [1:0] ST_FREE     = 2'd0;
    localparam logic [1:0] ST_ACTIVE   = 2'd1;
    localparam logic [1:0] ST_RETURNED = 2'd2;

    // field widths
    localparam int NOTE_W  = 32;
    localparam int OFFS_W  = 16;
    localparam int GROUP_W = 64;
    localparam int POS_W   = 8;
    localparam int STAMP_W = 64;
    localparam int DATA_W  = NOTE_W + OFFS_W + GROUP_W + POS_W;

    // controller to datapath commands
    typedef struct packed {
        logic capture;       // latch the input beat
        logic scan_en;       // step the free / oldest scan
        logic pick;          // choose the victim and read its voice data
        logic ret_read;      // read the voice data of the addressed slot
        logic lease_commit;  // write the leased slot, emit result
        logic ret_commit;    // return the addressed slot, emit result
        logic clear_commit;  // free every returned slot, emit result
        logic load_commit;   // write the addressed slot, emit result
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic scan_done;     // last slot compared this cycle
    } t_dp_stat;

endpackage

// ===== rtl/vaos_ram.sv =====
// ----------------------------------------------------------------------------
// vaos_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module vaos_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/vaos_ctrl.sv =====
// ----------------------------------------------------------------------------
// vaos_ctrl
// Command sequencer: decodes an accepted beat and steps the datapath through
// scan, read and commit phases.
// ----------------------------------------------------------------------------
module vaos_ctrl
    import vaos_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    input  logic [1:0] i_command,
    input  t_dp_stat   i_stat,
    output logic       busy,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_LEASE_RD,
        S_LEASE_WR,
        S_RET_RD,
        S_RET_WR,
        S_CLEAR,
        S_LOAD
    } t_state;

    t_state r_state, n_state;
    logic   r_busy;
    logic   w_accept;

    assign w_accept = start && !r_busy;
    assign busy     = r_busy;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_command)
                        CMD_LEASE:  n_state = S_SCAN;
                        CMD_RETURN: n_state = S_RET_RD;
                        CMD_CLEAR:  n_state = S_CLEAR;
                        CMD_LOAD:   n_state = S_LOAD;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_SCAN: begin
                if (i_stat.scan_done) begin
                    n_state = S_LEASE_RD;
                end
            end
            S_LEASE_RD: n_state = S_LEASE_WR;
            S_RET_RD:   n_state = S_RET_WR;
            S_LEASE_WR,
            S_RET_WR,
            S_CLEAR,
            S_LOAD:     n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // hold state and the registered busy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
        end
    end

    // decode datapath commands
    always_comb begin
        o_cmd              = '0;
        o_cmd.capture      = w_accept;
        o_cmd.scan_en      = (r_state == S_SCAN);
        o_cmd.pick         = (r_state == S_LEASE_RD);
        o_cmd.ret_read     = (r_state == S_RET_RD);
        o_cmd.lease_commit = (r_state == S_LEASE_WR);
        o_cmd.ret_commit   = (r_state == S_RET_WR);
        o_cmd.clear_commit = (r_state == S_CLEAR);
        o_cmd.load_commit  = (r_state == S_LOAD);
    end

endmodule

// ===== rtl/vaos_dp.sv =====
// ----------------------------------------------------------------------------
// vaos_dp
// Slot table datapath: per-slot state flops, stamp and voice-data RAMs,
// sequential free / oldest scan, and the result register.
// ----------------------------------------------------------------------------
module vaos_dp
    import vaos_pkg::*;
#(
    parameter int VOICES = VOICES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_dp_cmd                   i_cmd,
    output t_dp_stat                  o_stat,
    input  logic [1:0]                i_command,
    input  logic [4:0]                i_slot_index,
    input  logic [1:0]                i_load_state,
    input  logic [NOTE_W-1:0]         i_note_word,
    input  logic [OFFS_W-1:0]         i_note_offset,
    input  logic signed [GROUP_W-1:0] i_group_ident,
    input  logic [POS_W-1:0]          i_group_position,
    output logic [4:0]                o_granted_slot,
    output logic                      o_released_valid,
    output logic [NOTE_W-1:0]         o_released_note,
    output logic [OFFS_W-1:0]         o_released_offset,
    output logic signed [GROUP_W-1:0] o_released_group,
    output logic [POS_W-1:0]          o_released_position,
    output logic [5:0]                o_active_total,
    output logic [31:0]               o_occupied_mask,
    output logic                      o_error_flag,
    output logic                      o_done
);

    localparam int SLOT_W = $clog2(VOICES);
    localparam int CNT_W  = $clog2(VOICES + 1);
    localparam int MASK_N = (VOICES < 32) ? VOICES : 32;

    // slot states, written flags, lease counter, active count
    logic [1:0]         r_slot_st [VOICES];
    logic [1:0]         n_slot_st [VOICES];
    logic [VOICES-1:0]  r_written;
    logic [STAMP_W-1:0] r_lease_cnt;
    logic [CNT_W-1:0]   r_active_cnt, n_active_cnt;

    // captured beat
    logic [1:0]         r_cmd_code;
    logic [4:0]         r_slot_in;
    logic               r_in_range;
    logic [SLOT_W-1:0]  r_addr;
    logic [1:0]         r_load_st;
    logic [DATA_W-1:0]  r_data_in;

    // scan registers
    logic [CNT_W-1:0]   r_rd_idx;
    logic               r_cmp_valid;
    logic [SLOT_W-1:0]  r_cmp_idx;
    logic               r_free_found;
    logic [SLOT_W-1:0]  r_free_idx;
    logic [STAMP_W-1:0] r_best_stamp;
    logic [SLOT_W-1:0]  r_best_idx;
    logic [SLOT_W-1:0]  r_victim;
    logic [SLOT_W-1:0]  w_victim;
    logic [STAMP_W-1:0] w_cur_stamp;

    // result registers
    logic [4:0]         r_granted;
    logic               r_rel_valid;
    logic [DATA_W-1:0]  r_rel_data;
    logic [5:0]         r_active_tot;
    logic [31:0]        r_occ;
    logic               r_err;
    logic               r_done;

    // RAM ports
    logic               w_st_we;
    logic [SLOT_W-1:0]  w_st_waddr;
    logic [STAMP_W-1:0] w_st_wdata;
    logic [STAMP_W-1:0] w_st_rdata;
    logic               w_dt_we;
    logic [SLOT_W-1:0]  w_dt_waddr;
    logic [SLOT_W-1:0]  w_dt_raddr;
    logic [DATA_W-1:0]  w_dt_rdata;

    // commit helpers
    logic [SLOT_W-1:0]  w_rd_slot;
    logic [DATA_W-1:0]  w_old_data;
    logic               w_old_active;
    logic               w_ret_ok;
    logic [1:0]         w_load_new;
    logic [6:0]         w_cnt_ext;
    logic [6:0]         w_victim_ext;
    logic [VOICES-1:0]  w_active_vec;

    // ------------------------------------------------------------------
    // memories
    // ------------------------------------------------------------------
    vaos_ram #(.WIDTH(STAMP_W), .DEPTH(VOICES)) u_stamp_ram (
        .i_clk   (i_clk),
        .i_we    (w_st_we),
        .i_waddr (w_st_waddr),
        .i_wdata (w_st_wdata),
        .i_raddr (r_rd_idx[SLOT_W-1:0]),
        .o_rdata (w_st_rdata)
    );

    vaos_ram #(.WIDTH(DATA_W), .DEPTH(VOICES)) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (w_dt_we),
        .i_waddr (w_dt_waddr),
        .i_wdata (r_data_in),
        .i_raddr (w_dt_raddr),
        .o_rdata (w_dt_rdata)
    );

    // steer RAM write ports
    assign w_st_we    = i_cmd.lease_commit || (i_cmd.load_commit && r_in_range);
    assign w_st_waddr = i_cmd.lease_commit ? r_victim : r_addr;
    assign w_st_wdata = i_cmd.lease_commit ? (r_lease_cnt + 1'b1)
                                           : STAMP_W'(r_addr);
    assign w_dt_we    = w_st_we;
    assign w_dt_waddr = w_st_waddr;

    // choose victim: lowest free slot, else oldest stamp
    assign w_victim   = r_free_found ? r_free_idx : r_best_idx;
    assign w_dt_raddr = i_cmd.pick ? w_victim : r_addr;

    // unwritten entries read as their reset values
    assign w_cur_stamp = r_written[r_cmp_idx] ? w_st_rdata : STAMP_W'(r_cmp_idx);
    assign w_rd_slot   = i_cmd.lease_commit ? r_victim : r_addr;
    assign w_old_data  = r_written[w_rd_slot] ? w_dt_rdata : '0;
    assign w_old_active = (r_slot_st[w_rd_slot] == ST_ACTIVE);
    assign w_ret_ok    = r_in_range && w_old_active;
    assign w_load_new  = (r_load_st == ST_ACTIVE || r_load_st == ST_RETURNED)
                         ? r_load_st : ST_FREE;

    assign o_stat.scan_done = r_cmp_valid && (r_cmp_idx == SLOT_W'(VOICES - 1));

    // ------------------------------------------------------------------
    // next slot states and active count
    // ------------------------------------------------------------------
    always_comb begin
        n_active_cnt = r_active_cnt;
        for (int i = 0; i < VOICES; i++) begin
            n_slot_st[i] = r_slot_st[i];
            if (i_cmd.clear_commit && r_slot_st[i] == ST_RETURNED) begin
                n_slot_st[i] = ST_FREE;
            end
        end
        if (i_cmd.lease_commit) begin
            n_slot_st[r_victim] = ST_ACTIVE;
            if (!w_old_active) begin
                n_active_cnt = r_active_cnt + 1'b1;
            end
        end
        if (i_cmd.ret_commit && w_ret_ok) begin
            n_slot_st[r_addr] = ST_RETURNED;
            if (r_active_cnt != '0) begin
                n_active_cnt = r_active_cnt - 1'b1;
            end
        end
        if (i_cmd.load_commit && r_in_range) begin
            n_slot_st[r_addr] = w_load_new;
            n_active_cnt = r_active_cnt - CNT_W'(w_old_active)
                           + CNT_W'(w_load_new == ST_ACTIVE);
        end
    end

    assign w_cnt_ext    = 7'(n_active_cnt);
    assign w_victim_ext = 7'(r_victim);

    // ------------------------------------------------------------------
    // slot table state
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < VOICES; i++) begin
                r_slot_st[i] <= ST_FREE;
            end
            r_written    <= '0;
            r_lease_cnt  <= STAMP_W'(VOICES);
            r_active_cnt <= '0;
        end else begin
            for (int i = 0; i < VOICES; i++) begin
                r_slot_st[i] <= n_slot_st[i];
            end
            r_active_cnt <= n_active_cnt;
            if (w_st_we) begin
                r_written[w_st_waddr] <= 1'b1;
            end
            if (i_cmd.lease_commit) begin
                r_lease_cnt <= r_lease_cnt + 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // capture the input beat
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd_code <= i_command;
            r_slot_in  <= i_slot_index;
            r_in_range <= (7'(i_slot_index) < 7'(VOICES));
            r_addr     <= SLOT_W'(7'(i_slot_index));
            r_load_st  <= i_load_state;
            r_data_in  <= {i_note_word, i_note_offset, i_group_ident, i_group_position};
        end
    end

    // ------------------------------------------------------------------
    // scan: one stamp read a cycle, compared in the next cycle
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx     <= '0;
            r_cmp_valid  <= 1'b0;
            r_free_found <= 1'b0;
        end else if (i_cmd.capture) begin
            r_rd_idx     <= '0;
            r_cmp_valid  <= 1'b0;
            r_free_found <= 1'b0;
        end else if (i_cmd.scan_en) begin
            if (r_rd_idx < CNT_W'(VOICES)) begin
                r_rd_idx    <= r_rd_idx + 1'b1;
                r_cmp_valid <= 1'b1;
            end else begin
                r_cmp_valid <= 1'b0;
            end
            if (r_cmp_valid && !r_free_found && r_slot_st[r_cmp_idx] == ST_FREE) begin
                r_free_found <= 1'b1;
            end
        end else begin
            r_cmp_valid <= 1'b0;
        end
    end

    // scan payload: index in flight, first free, oldest so far, victim
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_en) begin
            r_cmp_idx <= r_rd_idx[SLOT_W-1:0];
            if (r_cmp_valid) begin
                if (!r_free_found && r_slot_st[r_cmp_idx] == ST_FREE) begin
                    r_free_idx <= r_cmp_idx;
                end
                // ties keep the lower slot
                if (r_cmp_idx == '0 || w_cur_stamp < r_best_stamp) begin
                    r_best_stamp <= w_cur_stamp;
                    r_best_idx   <= r_cmp_idx;
                end
            end
        end
        if (i_cmd.pick) begin
            r_victim <= w_victim;
        end
    end

    // ------------------------------------------------------------------
    // result register: one strobe per command
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.lease_commit || i_cmd.ret_commit
                      || i_cmd.clear_commit || i_cmd.load_commit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.lease_commit || i_cmd.ret_commit
            || i_cmd.clear_commit || i_cmd.load_commit) begin
            r_rel_valid  <= 1'b0;
            r_rel_data   <= '0;
            r_err        <= 1'b0;
            r_granted    <= r_slot_in;
            r_active_tot <= (w_cnt_ext > 7'd63) ? 6'd63 : w_cnt_ext[5:0];
            for (int i = 0; i < 32; i++) begin
                r_occ[i] <= (i < MASK_N) ? (n_slot_st[i % VOICES] != ST_FREE) : 1'b0;
            end
            if (i_cmd.lease_commit) begin
                r_granted <= w_victim_ext[4:0];
                if (w_old_active) begin
                    r_rel_valid <= 1'b1;
                    r_rel_data  <= w_old_data;
                end
            end
            if (i_cmd.ret_commit) begin
                if (w_ret_ok) begin
                    r_rel_valid <= 1'b1;
                    r_rel_data  <= w_old_data;
                end else begin
                    r_err <= 1'b1;
                end
            end
            if (i_cmd.clear_commit) begin
                r_granted <= 5'd0;
            end
        end
    end

    assign o_done              = r_done;
    assign o_granted_slot      = r_granted;
    assign o_released_valid    = r_rel_valid;
    assign o_released_position = r_rel_data[POS_W-1:0];
    assign o_released_group    = $signed(r_rel_data[POS_W +: GROUP_W]);
    assign o_released_offset   = r_rel_data[POS_W+GROUP_W +: OFFS_W];
    assign o_released_note     = r_rel_data[POS_W+GROUP_W+OFFS_W +: NOTE_W];
    assign o_active_total      = r_active_tot;
    assign o_occupied_mask     = r_occ;
    assign o_error_flag        = r_err;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    always_comb begin
        for (int i = 0; i < VOICES; i++) begin
            w_active_vec[i] = (r_slot_st[i] == ST_ACTIVE);
        end
    end

    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'($countones(w_active_vec)) == 32'(r_active_cnt))
        else $error("active count out of step with slot states");

    a_err_only_return: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_err) |-> (r_cmd_code == CMD_RETURN && !r_rel_valid))
        else $error("error flag on a command other than return");

    a_rel_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && !r_rel_valid) |-> (r_rel_data == '0))
        else $error("released data not cleared without a release");

    a_commit_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.lease_commit || i_cmd.ret_commit || i_cmd.clear_commit
         || i_cmd.load_commit) |=> !(i_cmd.lease_commit || i_cmd.ret_commit
         || i_cmd.clear_commit || i_cmd.load_commit))
        else $error("back-to-back commits for one beat");

endmodule

// ===== rtl/voice_allocator_oldest_steal_core.sv =====
// ----------------------------------------------------------------------------
// voice_allocator_oldest_steal_core
// Voice slot table with lowest-free lease and oldest-stamp stealing.
//
//  channel   | signals                                   | direction
//  ----------+-------------------------------------------+----------
//  command   | start, busy, i_command .. i_group_position | in, busy out
//  result    | o_done, o_granted_slot .. o_error_flag     | out
//
// Lease: a scan reads one age stamp per cycle from the stamp RAM, then the
// victim's voice data is read and the slot is written before the o_done strobe.
// Return does one voice-data RAM read, then commits; clear and load commit directly.
// busy drops as the strobe appears; a new beat can be accepted then.
// Reset is synchronous and needs no clearing pass: per-slot written flags
// make unwritten entries read as their reset values.
// o_done is high for one cycle per beat; the receiver cannot stall.
// ----------------------------------------------------------------------------
module voice_allocator_oldest_steal_core
    import vaos_pkg::*;
#(
    parameter int VOICES = VOICES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                i_command,
    input  logic [4:0]                i_slot_index,
    input  logic [1:0]                i_load_state,
    input  logic [NOTE_W-1:0]         i_note_word,
    input  logic [OFFS_W-1:0]         i_note_offset,
    input  logic signed [GROUP_W-1:0] i_group_ident,
    input  logic [POS_W-1:0]          i_group_position,
    output logic                      o_done,
    output logic [4:0]                o_granted_slot,
    output logic                      o_released_valid,
    output logic [NOTE_W-1:0]         o_released_note,
    output logic [OFFS_W-1:0]         o_released_offset,
    output logic signed [GROUP_W-1:0] o_released_group,
    output logic [POS_W-1:0]          o_released_position,
    output logic [5:0]                o_active_total,
    output logic [31:0]               o_occupied_mask,
    output logic                      o_error_flag
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // sequencer
    vaos_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .i_command (i_command),
        .i_stat    (w_stat),
        .busy      (busy),
        .o_cmd     (w_cmd)
    );

    // slot table datapath
    vaos_dp #(.VOICES(VOICES)) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .o_stat              (w_stat),
        .i_command           (i_command),
        .i_slot_index        (i_slot_index),
        .i_load_state        (i_load_state),
        .i_note_word         (i_note_word),
        .i_note_offset       (i_note_offset),
        .i_group_ident       (i_group_ident),
        .i_group_position    (i_group_position),
        .o_granted_slot      (o_granted_slot),
        .o_released_valid    (o_released_valid),
        .o_released_note     (o_released_note),
        .o_released_offset   (o_released_offset),
        .o_released_group    (o_released_group),
        .o_released_position (o_released_position),
        .o_active_total      (o_active_total),
        .o_occupied_mask     (o_occupied_mask),
        .o_error_flag        (o_error_flag),
        .o_done              (o_done)
    );

endmodule
